>>> rtl/khd_pkg.sv
`default_nettype none
// ============================================================================
// Touch keypad hold decoder package
// Shared widths, register indexes, state encoding and record types.
// ============================================================================
package khd_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int ID_W      = 16;
    localparam int BYTE_W    = 8;
    localparam int MASK_W    = 16;
    localparam int TIME_W    = 48;
    localparam int HOLD_W    = 24;
    localparam int KEY_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 24'd150000;
    localparam logic [KEY_W-1:0]  KEY_NONE   = 5'h1F;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EVAL,
        ST_EMIT
    } khd_state_t;

    // One slot of the table.
    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [MASK_W-1:0] mask;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    // Result handed from the engine to the output stage.
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              full;
    } res_t;

endpackage
`default_nettype wire

>>> rtl/khd_slot_mem.sv
`default_nettype none
// ============================================================================
// Slot table memory
// One write port and one read port; the read data is registered.
// ============================================================================
module khd_slot_mem #(
    parameter int DEPTH = khd_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [IDX_W-1:0]  waddr,
    input  wire khd_pkg::entry_t   wdata,
    input  wire logic              re,
    input  wire logic [IDX_W-1:0]  raddr,
    output khd_pkg::entry_t        rdata
);
    import khd_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/khd_engine.sv
`default_nettype none
// ============================================================================
// Slot search and update engine
// Walks the claimed slots for the sensor id, claims a new slot or flags a
// full table, then applies the hold rule and writes the slot back when it changes.
// ============================================================================
module khd_engine #(
    parameter int SLOT_COUNT = khd_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [khd_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [khd_pkg::HOLD_W-1:0]    hold_time,
    input  wire logic                          first_byte_high,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output khd_pkg::res_t                      res,
    output logic                               mem_we,
    output logic [IDX_W-1:0]                   mem_waddr,
    output khd_pkg::entry_t                    mem_wdata,
    output logic                               mem_re,
    output logic [IDX_W-1:0]                   mem_raddr,
    input  wire khd_pkg::entry_t               mem_rdata
);
    import khd_pkg::*;

    khd_state_t        state_reg, state_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [MASK_W-1:0] raw_reg, raw_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              hit_reg, hit_next;
    logic              full_reg, full_next;
    res_t              res_reg, res_next;

    logic [BYTE_W-1:0] b0, b1;
    logic [MASK_W-1:0] raw_in;
    logic [TIME_W-1:0] elapsed;
    logic              stretch;

    assign b0     = s_tdata[ID_W +: BYTE_W];
    assign b1     = s_tdata[ID_W+BYTE_W +: BYTE_W];
    assign raw_in = first_byte_high ? {b0, b1} : {b1, b0};

    // Elapsed time wraps modulo the width of the time stamp.
    assign elapsed = now_reg - mem_rdata.stamp;
    assign stretch = (mem_rdata.mask != '0) &&
                     (elapsed < {{(TIME_W-HOLD_W){1'b0}}, hold_time});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        raw_reg  <= raw_next;
        now_reg  <= now_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        full_reg <= full_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        id_next    = id_reg;
        raw_next   = raw_reg;
        now_next   = now_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        hit_next   = hit_reg;
        full_next  = full_reg;
        res_next   = res_reg;
        s_tready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    id_next   = s_tdata[ID_W-1:0];
                    raw_next  = raw_in;
                    now_next  = s_tdata[ID_W+2*BYTE_W +: TIME_W];
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    full_next = 1'b0;
                    if (fill_reg == '0) begin
                        state_next = ST_EVAL;
                    end else begin
                        mem_re     = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // The read data belongs to the slot at idx_reg.
                if (mem_rdata.owner == id_reg) begin
                    hit_next   = 1'b1;
                    state_next = ST_EVAL;
                end else if ((CNT_W'(idx_reg) + CNT_W'(1)) < fill_reg) begin
                    idx_next   = idx_reg + IDX_W'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg + IDX_W'(1);
                end else begin
                    state_next = ST_EVAL;
                    if (fill_reg < CNT_W'(SLOT_COUNT)) begin
                        idx_next = fill_reg[IDX_W-1:0];
                    end else begin
                        full_next = 1'b1;
                    end
                end
            end
            ST_EVAL: begin
                state_next = ST_EMIT;
                res_next.full = full_reg;
                res_next.mask = raw_reg;
                if (full_reg) begin
                    res_next.mask = raw_reg;
                end else if (!hit_reg) begin
                    mem_we          = 1'b1;
                    mem_wdata.owner = id_reg;
                    mem_wdata.mask  = raw_reg;
                    mem_wdata.stamp = (raw_reg != '0) ? now_reg : '0;
                    fill_next       = fill_reg + CNT_W'(1);
                end else if (raw_reg != '0) begin
                    mem_we          = 1'b1;
                    mem_wdata.owner = id_reg;
                    mem_wdata.mask  = raw_reg;
                    mem_wdata.stamp = now_reg;
                end else if (stretch) begin
                    res_next.mask = mem_rdata.mask;
                end else begin
                    mem_we         = 1'b1;
                    mem_wdata.mask = '0;
                    res_next.mask  = '0;
                end
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(SLOT_COUNT))
        else $error("slot fill count beyond table size");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (fill_reg != $past(fill_reg)) |->
            (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("slot fill count moved by more than one");

    a_read_claimed: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |-> (CNT_W'(mem_raddr) < fill_reg))
        else $error("read of an unclaimed slot");

    a_write_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_EVAL) && !full_reg)
        else $error("slot write outside the update step or with a full table");

endmodule
`default_nettype wire

>>> rtl/khd_out.sv
`default_nettype none
// ============================================================================
// Result output stage
// Derives the lowest touched pad and touch count and holds the result in a
// register until the downstream transfer completes.
// ============================================================================
module khd_out (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          res_valid,
    output logic                               res_ready,
    input  wire khd_pkg::res_t                 res,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [khd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser
);
    import khd_pkg::*;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] tdata_reg;
    logic                 tuser_reg;
    logic [KEY_W-1:0]     lowest;
    logic [COUNT_W-1:0]   count;

    always_comb begin
        lowest = KEY_NONE;
        count  = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (res.mask[i]) begin
                lowest = KEY_W'(i);
                count  = count + COUNT_W'(1);
            end
        end
    end

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            tdata_reg <= {{(M_TDATA_W-KEY_W-MASK_W-COUNT_W){1'b0}}, count, res.mask, lowest};
            tuser_reg <= res.full;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule
`default_nettype wire

>>> rtl/touch_keypad_hold_decoder.sv
`default_nettype none
// ============================================================================
// Touch keypad hold decoder
// Per-keypad touch stretcher: joins the two key bytes into a pad mask and
// holds it per sensor in a slot table until the hold time has run out.
// ============================================================================
//  Channel  Dir  Payload
//  s_       in   tdata: sensor_id, first_byte, second_byte, now_us
//  m_       out  tdata: lowest_key, touch_mask, touch_count; tuser: table_full
//  cfg_     in   index 0 hold_time_us, index 1 first_byte_high
//
//  An item passes from its input transfer through the search, the update step
//  and the output stage to its result. The search reads one slot for each slot
//  up to and including the match, or every claimed slot (at most SLOT_COUNT)
//  for a new sensor or a full table, one slot a cycle through the single read port.
//  Items are handled one at a time; the output register lets the next input
//  transfer in while a result still waits for m_tready.
//  Reset clears the fill count, engine state and output valid and sets the config;
//  the slot memory is not cleared, as only claimed slots are ever read.
// ============================================================================
module touch_keypad_hold_decoder #(
    parameter int SLOT_COUNT = khd_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // [15:0] sensor_id, [23:16] first_byte, [31:24] second_byte, [79:32] now_us
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [khd_pkg::S_TDATA_W-1:0] s_tdata,
    // [4:0] lowest_key, [20:5] touch_mask, [25:21] touch_count, rest zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [khd_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] table_full
    output logic                               m_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [khd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [khd_pkg::HOLD_W-1:0]    cfg_data
);
    import khd_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    logic [HOLD_W-1:0] hold_time_reg;
    logic              byte_order_reg;
    logic              res_valid, res_ready;
    res_t              res;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    entry_t            mem_wdata, mem_rdata;

    assign cfg_ready = 1'b1;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_time_reg  <= HOLD_RESET;
            byte_order_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_HOLD_TIME) begin
                hold_time_reg <= cfg_data;
            end else if (cfg_index == CFG_BYTE_ORDER) begin
                byte_order_reg <= cfg_data[0];
            end
        end
    end

    khd_engine #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .hold_time       (hold_time_reg),
        .first_byte_high (byte_order_reg),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    khd_slot_mem #(
        .DEPTH (SLOT_COUNT),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    khd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
